@@ rtl/pba_pkg.sv @@
// Package for the page bitmap allocator: field widths, codes and defaults.
// No dependencies; every other file of the block but pba_map_ram and pba_bit_pick uses it.
`default_nettype none

package pba_pkg;

   localparam int CFG_W      = 11;
   localparam int PAGE_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 11;
   localparam int CSR_IDX_W  = 2;

   localparam int PAGE_COUNT_DEFAULT = 1024;
   localparam int WORD_BITS_DEFAULT  = 32;

   localparam logic [CFG_W-1:0] FIRST_FREE_RESET  = 11'd0;
   localparam logic [CFG_W-1:0] TOTAL_PAGES_RESET = 11'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PAGES = 2'd1;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_NO_PAGE = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_BUILD = 6'b000010,
      S_SCAN  = 6'b000100,
      S_PICK  = 6'b001000,
      S_DONE  = 6'b010000,
      S_SPARE = 6'b100000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/pba_req_if.sv @@
// Request channel of the page bitmap allocator: valid/ready plus op and page.
// Depends on pba_pkg for the field widths.
`default_nettype none

interface pba_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [pba_pkg::PAGE_W-1:0]  page;

   modport source (output valid, output op, output page, input ready);
   modport sink   (input valid, input op, input page, output ready);
endinterface

`default_nettype wire

@@ rtl/pba_rsp_if.sv @@
// Response channel of the page bitmap allocator: valid/ready plus result fields.
// Depends on pba_pkg for the field widths.
`default_nettype none

interface pba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pba_pkg::PAGE_W-1:0]    page_number;
   logic [pba_pkg::STATUS_W-1:0]  status;
   logic [pba_pkg::COUNT_W-1:0]   free_count;

   modport source (output valid, output page_number, output status, output free_count,
                   input ready);
   modport sink   (input valid, input page_number, input status, input free_count,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/pba_map_ram.sv @@
// Free-page bitmap storage: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module pba_map_ram #(
   parameter int WORDS  = 32,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] map_mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/pba_fill_mask.sv @@
// Rebuild word generator: marks bits of one map word whose pages fall in [first, limit).
// Depends on pba_pkg for the register width.
`default_nettype none

module pba_fill_mask #(
   parameter int WORD_BITS = 32,
   parameter int WIDE_W    = 11
) (
   input  wire logic [WIDE_W-1:0]       base,
   input  wire logic [pba_pkg::CFG_W-1:0] first,
   input  wire logic [WIDE_W-1:0]       limit,
   output      logic [WORD_BITS-1:0]    mask
);

   localparam int                OFS_W     = $clog2(WORD_BITS + 1);
   localparam logic [WIDE_W-1:0] WORD_STEP = WIDE_W'(WORD_BITS);
   localparam logic [OFS_W-1:0]  FULL_OFS  = OFS_W'(WORD_BITS);

   logic [WIDE_W-1:0] first_ext;
   logic [WIDE_W-1:0] top;
   logic [OFS_W-1:0]  lo_ofs;
   logic [OFS_W-1:0]  hi_ofs;

   always_comb begin
      first_ext = WIDE_W'(first);
      top       = base + WORD_STEP;

      if (first_ext <= base) begin
         lo_ofs = '0;
      end else if (first_ext >= top) begin
         lo_ofs = FULL_OFS;
      end else begin
         lo_ofs = OFS_W'(first_ext - base);
      end

      if (limit <= base) begin
         hi_ofs = '0;
      end else if (limit >= top) begin
         hi_ofs = FULL_OFS;
      end else begin
         hi_ofs = OFS_W'(limit - base);
      end

      for (int i = 0; i < WORD_BITS; i++) begin
         mask[i] = (OFS_W'(i) >= lo_ofs) && (OFS_W'(i) < hi_ofs);
      end
   end

endmodule

`default_nettype wire

@@ rtl/pba_bit_pick.sv @@
// Bit unit: finds the lowest set bit of a map word, or decodes a given bit offset.
// No package dependencies.
`default_nettype none

module pba_bit_pick #(
   parameter int WORD_BITS = 32,
   parameter int BI_W      = 5
) (
   input  wire logic [WORD_BITS-1:0] word,
   input  wire logic                 find,
   input  wire logic [BI_W-1:0]      offset,
   output      logic [WORD_BITS-1:0] onehot,
   output      logic [BI_W-1:0]      index
);

   logic [WORD_BITS-1:0] lowest;
   logic [WORD_BITS-1:0] decoded;
   logic [BI_W-1:0]      lowest_idx;

   always_comb begin
      lowest     = word & (~word + WORD_BITS'(1));
      lowest_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         decoded[i] = (offset == BI_W'(i));
         for (int j = 0; j < BI_W; j++) begin
            if (((i >> j) & 1) == 1) begin
               lowest_idx[j] = lowest_idx[j] | lowest[i];
            end
         end
      end
      onehot = find ? lowest : decoded;
      index  = find ? lowest_idx : offset;
   end

endmodule

`default_nettype wire

@@ rtl/page_bitmap_allocator_unit.sv @@
// Page bitmap allocator. An allocate scans the bitmap one word per cycle through the map
// memory's read port, from word 0 to the first word holding a free page or to the last
// word when none is found; a free walks the same scan up to the page's word. An allocate
// with a zero count or an out-of-range free skips the scan and goes straight to its
// response. A new request word is taken only after the response word is loaded, and
// loading waits while the previous response word is still held. After reset and after
// each write to the first-free or total-pages register the map is rebuilt word by word
// over all MAP_WORDS words (32 by default), during which no request word is taken.
// Depends on pba_pkg, pba_req_if, pba_rsp_if, pba_map_ram, pba_fill_mask, pba_bit_pick.
`default_nettype none

module page_bitmap_allocator_unit #(
   parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEFAULT,
   parameter int WORD_BITS  = pba_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [pba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pba_pkg::CFG_W-1:0]      csr_wdata,
   pba_req_if.sink                             req_bus,
   pba_rsp_if.source                           rsp_bus
);

   localparam int MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BI_W      = $clog2(WORD_BITS);
   localparam int ADDR_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
   localparam int WIDE_W    = (ADDR_W > pba_pkg::CFG_W) ? ADDR_W : pba_pkg::CFG_W;
   localparam int PAGE_W    = pba_pkg::PAGE_W;
   localparam int COUNT_W   = pba_pkg::COUNT_W;

   localparam logic [WI_W-1:0]   LAST_WORD = WI_W'(MAP_WORDS - 1);
   localparam logic [WIDE_W-1:0] WORD_STEP = WIDE_W'(WORD_BITS);
   localparam logic [WIDE_W-1:0] PAGE_CAP  = WIDE_W'(PAGE_COUNT);

   pba_pkg::state_type             state_ff, state_in;
   logic [pba_pkg::CFG_W-1:0]      first_ff, first_in;
   logic [pba_pkg::CFG_W-1:0]      total_ff, total_in;
   logic [WI_W-1:0]                ptr_ff, ptr_in;
   logic [WIDE_W-1:0]              base_ff, base_in;
   logic                           chk_valid_ff, chk_valid_in;
   logic [WI_W-1:0]                chk_ptr_ff, chk_ptr_in;
   logic [WIDE_W-1:0]              chk_base_ff, chk_base_in;
   pba_pkg::op_type                op_ff, op_in;
   logic [WIDE_W-1:0]              page_ff, page_in;
   logic [WORD_BITS-1:0]           word_ff, word_in;
   logic [WI_W-1:0]                hit_ptr_ff, hit_ptr_in;
   logic [WIDE_W-1:0]              hit_base_ff, hit_base_in;
   logic [COUNT_W-1:0]             count_ff, count_in;
   logic [PAGE_W-1:0]              res_page_ff, res_page_in;
   pba_pkg::status_type            res_status_ff, res_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]              rsp_page_ff, rsp_page_in;
   pba_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]             rsp_count_ff, rsp_count_in;

   logic [WIDE_W-1:0]              limit;
   logic [COUNT_W-1:0]             fill_count;
   logic [WORD_BITS-1:0]           fill_mask;
   logic [WORD_BITS-1:0]           rd_data;
   logic                           ram_we;
   logic [WI_W-1:0]                ram_waddr;
   logic [WORD_BITS-1:0]           ram_wdata;
   logic [WORD_BITS-1:0]           pick_onehot;
   logic [BI_W-1:0]                pick_index;
   logic [BI_W-1:0]                free_offset;
   logic [WIDE_W-1:0]              granted;
   logic [WIDE_W-1:0]              chk_end;
   logic [WIDE_W-1:0]              req_page_ext;
   logic                           hit;

   pba_map_ram #(
      .WORDS  (MAP_WORDS),
      .WIDTH  (WORD_BITS),
      .ADDR_W (WI_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   pba_fill_mask #(
      .WORD_BITS (WORD_BITS),
      .WIDE_W    (WIDE_W)
   ) u_fill_mask (
      .base  (base_ff),
      .first (first_ff),
      .limit (limit),
      .mask  (fill_mask)
   );

   pba_bit_pick #(
      .WORD_BITS (WORD_BITS),
      .BI_W      (BI_W)
   ) u_bit_pick (
      .word   (word_ff),
      .find   (op_ff == pba_pkg::OP_ALLOC),
      .offset (free_offset),
      .onehot (pick_onehot),
      .index  (pick_index)
   );

   always_comb begin
      limit        = (WIDE_W'(total_ff) < PAGE_CAP) ? WIDE_W'(total_ff) : PAGE_CAP;
      fill_count   = (limit > WIDE_W'(first_ff)) ? COUNT_W'(limit - WIDE_W'(first_ff)) : '0;
      free_offset  = BI_W'(page_ff - hit_base_ff);
      granted      = hit_base_ff + WIDE_W'(pick_index);
      chk_end      = chk_base_ff + WORD_STEP;
      req_page_ext = WIDE_W'(req_bus.page);
      hit          = (op_ff == pba_pkg::OP_ALLOC) ? (rd_data != '0) : (page_ff < chk_end);
   end

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      total_in      = total_ff;
      ptr_in        = ptr_ff;
      base_in       = base_ff;
      chk_valid_in  = chk_valid_ff;
      chk_ptr_in    = chk_ptr_ff;
      chk_base_in   = chk_base_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      word_in       = word_ff;
      hit_ptr_in    = hit_ptr_ff;
      hit_base_in   = hit_base_ff;
      count_in      = count_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff;
      ram_wdata     = fill_mask;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pba_pkg::S_BUILD: begin
            ram_we   = 1'b1;
            count_in = fill_count;
            if (ptr_ff == LAST_WORD) begin
               state_in = pba_pkg::S_IDLE;
            end else begin
               ptr_in  = ptr_ff + WI_W'(1);
               base_in = base_ff + WORD_STEP;
            end
         end
         pba_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               op_in        = pba_pkg::op_type'(req_bus.op);
               page_in      = req_page_ext;
               ptr_in       = '0;
               base_in      = '0;
               chk_valid_in = 1'b0;
               state_in     = pba_pkg::S_SCAN;
               if (pba_pkg::op_type'(req_bus.op) == pba_pkg::OP_ALLOC) begin
                  if (count_ff == '0) begin
                     res_page_in   = '0;
                     res_status_in = pba_pkg::STATUS_NO_PAGE;
                     state_in      = pba_pkg::S_DONE;
                  end
               end else if (req_page_ext >= limit) begin
                  res_page_in   = '0;
                  res_status_in = pba_pkg::STATUS_IGNORED;
                  state_in      = pba_pkg::S_DONE;
               end
            end
         end
         pba_pkg::S_SCAN: begin
            chk_valid_in = 1'b1;
            chk_ptr_in   = ptr_ff;
            chk_base_in  = base_ff;
            if (ptr_ff == LAST_WORD) begin
               ptr_in  = '0;
               base_in = '0;
            end else begin
               ptr_in  = ptr_ff + WI_W'(1);
               base_in = base_ff + WORD_STEP;
            end
            if (chk_valid_ff) begin
               if (hit) begin
                  word_in     = rd_data;
                  hit_ptr_in  = chk_ptr_ff;
                  hit_base_in = chk_base_ff;
                  state_in    = pba_pkg::S_PICK;
               end else if (chk_ptr_ff == LAST_WORD) begin
                  res_page_in   = '0;
                  res_status_in = (op_ff == pba_pkg::OP_ALLOC) ? pba_pkg::STATUS_NO_PAGE
                                                               : pba_pkg::STATUS_IGNORED;
                  state_in      = pba_pkg::S_DONE;
               end
            end
         end
         pba_pkg::S_PICK: begin
            ram_waddr = hit_ptr_ff;
            state_in  = pba_pkg::S_DONE;
            if (op_ff == pba_pkg::OP_ALLOC) begin
               ram_we        = 1'b1;
               ram_wdata     = word_ff & ~pick_onehot;
               res_page_in   = granted[PAGE_W-1:0];
               res_status_in = pba_pkg::STATUS_DONE;
               count_in      = count_ff - COUNT_W'(1);
            end else begin
               ram_wdata   = word_ff | pick_onehot;
               res_page_in = '0;
               if ((word_ff & pick_onehot) != '0) begin
                  res_status_in = pba_pkg::STATUS_IGNORED;
               end else begin
                  ram_we        = 1'b1;
                  res_status_in = pba_pkg::STATUS_DONE;
                  count_in      = count_ff + COUNT_W'(1);
               end
            end
         end
         pba_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = res_page_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = pba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pba_pkg::S_IDLE;
         end
      endcase

      if (csr_wr_en && (csr_index == pba_pkg::CSR_FIRST_FREE ||
                        csr_index == pba_pkg::CSR_TOTAL_PAGES)) begin
         if (csr_index == pba_pkg::CSR_FIRST_FREE) begin
            first_in = csr_wdata;
         end else begin
            total_in = csr_wdata;
         end
         state_in = pba_pkg::S_BUILD;
         ptr_in   = '0;
         base_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pba_pkg::S_BUILD;
         first_ff     <= pba_pkg::FIRST_FREE_RESET;
         total_ff     <= pba_pkg::TOTAL_PAGES_RESET;
         ptr_ff       <= '0;
         base_ff      <= '0;
         chk_valid_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         total_ff     <= total_in;
         ptr_ff       <= ptr_in;
         base_ff      <= base_in;
         chk_valid_ff <= chk_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ptr_ff    <= chk_ptr_in;
      chk_base_ff   <= chk_base_in;
      op_ff         <= op_in;
      page_ff       <= page_in;
      word_ff       <= word_in;
      hit_ptr_ff    <= hit_ptr_in;
      hit_base_ff   <= hit_base_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_bus.ready       = (state_ff == pba_pkg::S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.page_number = rsp_page_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.free_count  = rsp_count_ff;

endmodule

`default_nettype wire

@@ rtl/pba_checker.sv @@
// Port checks for the page bitmap allocator, bound to the top level.
// Depends on pba_pkg for status codes and widths.
`default_nettype none

module pba_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [pba_pkg::PAGE_W-1:0]    rsp_page_number,
   input wire logic [pba_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [pba_pkg::COUNT_W-1:0]   rsp_free_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && !rsp_ready)) |->
         (rsp_valid && $stable(rsp_page_number) && $stable(rsp_status) &&
          $stable(rsp_free_count)))
      else $error("response word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a word is in work");

   a_no_page_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pba_pkg::STATUS_NO_PAGE) |->
         (rsp_page_number == '0 && rsp_free_count == '0))
      else $error("no-page response with free pages or a page number");

   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pba_pkg::STATUS_IGNORED) |-> rsp_page_number == '0)
      else $error("ignored free carries a page number");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_page_number (rsp_bus.page_number),
   .rsp_status      (rsp_bus.status),
   .rsp_free_count  (rsp_bus.free_count)
);

`default_nettype wire
